/* src/mrac_pkg.sv */
// Shared types and constants for the memory region access checker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mrac_pkg;

  localparam int Regions = 16;
  localparam int RegIdxW = $clog2(Regions);

  localparam logic [2:0] FUNC_LOAD  = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_SIZE  = 3'd3;
  localparam logic [2:0] FUNC_NEXT  = 3'd4;

  localparam logic [2:0] SIZE_DEFAULT = 3'd2;
  localparam logic [2:0] SIZE_WORD    = 3'd4;
  localparam logic [2:0] SIZE_HALF    = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming word and start a query
    logic step;      // examine the entry at the scan index
    logic align;     // align the found address within its region
    logic finish;    // form the result from the align outcome
  } mrac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;   // word is a load or an unknown code: no scan needed
    logic scan_done; // the scan has settled on an answer
    logic need_align;// the answer still needs the alignment step
  } mrac_stat_t;

endpackage

/* src/mrac_datapath.sv */
// Datapath of the region checker: region table, scan index and result registers.
// Depends on mrac_pkg.
`timescale 1ns / 1ps

module mrac_datapath import mrac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  mrac_cmd_t           cmd,
  output mrac_stat_t          stat,
  input  logic [2:0]          func,
  input  logic [3:0]          entry_index,
  input  logic [31:0]         entry_begin,
  input  logic [31:0]         entry_end,
  input  logic                entry_read_ok,
  input  logic                entry_write_ok,
  input  logic [7:0]          entry_id,
  input  logic [2:0]          entry_access_size,
  input  logic [31:0]         address,
  input  logic [15:0]         word_count,
  input  logic [31:0]         base_address,
  output logic                res_granted,
  output logic [7:0]          res_matched_id,
  output logic [2:0]          res_access_size,
  output logic [31:0]         res_next_address
);

  // Region table, written by loads.
  logic [31:0] tbl_begin [Regions];
  logic [31:0] tbl_end   [Regions];
  logic        tbl_rd    [Regions];
  logic        tbl_wr    [Regions];
  logic [7:0]  tbl_id    [Regions];
  logic [2:0]  tbl_size  [Regions];

  // Captured query.
  logic [2:0]  q_func;
  logic [31:0] q_addr;
  logic [31:0] q_span;
  logic [31:0] q_base;
  logic        q_fwd;
  logic        q_bad_span;

  // Scan state.
  logic [RegIdxW-1:0] idx;
  logic               done;
  logic               pend_align;
  logic [RegIdxW-1:0] area;
  logic [31:0]        cand;

  logic [31:0] span_calc;
  assign span_calc = address + {15'd0, word_count, 1'b0} - 32'd1;

  // Entry under examination and its neighbors.
  localparam logic [RegIdxW-1:0] LastIdx = RegIdxW'(Regions - 1);
  logic [RegIdxW-1:0] idx_up, idx_dn;
  assign idx_up = idx + RegIdxW'(1);
  assign idx_dn = idx - RegIdxW'(1);

  logic [31:0] cur_b, cur_e, up_b, dn_e;
  logic        cur_holds;
  assign cur_b = tbl_begin[idx];
  assign cur_e = tbl_end[idx];
  assign up_b  = tbl_begin[idx_up];
  assign dn_e  = tbl_end[idx_dn];
  assign cur_holds = (cur_b <= q_addr) && (q_addr <= cur_e);

  // Alignment of the candidate inside its region.
  logic [31:0] al_addr;
  logic [2:0]  ar_size;
  assign ar_size = tbl_size[area];
  always_comb begin
    al_addr = cand;
    if (ar_size == SIZE_WORD) begin
      al_addr = q_fwd ? ((cand + 32'd3) & ~32'd3) : (cand & ~32'd3);
    end else if (ar_size == SIZE_HALF) begin
      al_addr = q_fwd ? ((cand + 32'd1) & ~32'd1) : (cand & ~32'd1);
    end
  end

  logic [RegIdxW-1:0] area_up, area_dn;
  assign area_up = area + RegIdxW'(1);
  assign area_dn = area - RegIdxW'(1);

  assign stat.is_load    = (func == FUNC_LOAD) || (func > FUNC_NEXT);
  assign stat.scan_done  = done;
  assign stat.need_align = pend_align;

  // Table writes.
  always_ff @(posedge clk) begin
    if (cmd.capture && func == FUNC_LOAD && 32'(entry_index) < Regions) begin
      tbl_begin[entry_index[RegIdxW-1:0]] <= entry_begin;
      tbl_end[entry_index[RegIdxW-1:0]]   <= entry_end;
      tbl_rd[entry_index[RegIdxW-1:0]]    <= entry_read_ok;
      tbl_wr[entry_index[RegIdxW-1:0]]    <= entry_write_ok;
      tbl_id[entry_index[RegIdxW-1:0]]    <= entry_id;
      tbl_size[entry_index[RegIdxW-1:0]]  <= entry_access_size;
    end
  end

  // Query capture, scan and result formation.
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      pend_align <= 1'b0;
    end else if (cmd.capture) begin
      q_func           <= func;
      q_addr           <= address;
      q_span           <= span_calc;
      q_base           <= base_address;
      q_fwd            <= address >= base_address;
      q_bad_span       <= span_calc <= address;
      idx              <= (address >= base_address || func != FUNC_NEXT) ? '0 : LastIdx;
      done             <= 1'b0;
      pend_align       <= 1'b0;
      res_granted      <= 1'b0;
      res_matched_id   <= 8'd0;
      res_access_size  <= 3'd0;
      res_next_address <= 32'd0;
    end else if (cmd.step) begin
      case (q_func)
        FUNC_READ, FUNC_WRITE: begin
          if (q_bad_span) begin
            done <= 1'b1;
          end else if (cur_b <= q_addr && q_span <= cur_e) begin
            res_granted    <= (q_func == FUNC_WRITE) ? tbl_wr[idx] : tbl_rd[idx];
            res_matched_id <= ((q_func == FUNC_WRITE) ? tbl_wr[idx] : tbl_rd[idx])
                              ? tbl_id[idx] : 8'd0;
            done <= 1'b1;
          end else if (idx == LastIdx) begin
            done <= 1'b1;
          end
          idx <= idx_up;
        end
        FUNC_SIZE: begin
          if (cur_holds) begin
            res_access_size <= tbl_size[idx];
            done <= 1'b1;
          end else if (idx == LastIdx) begin
            res_access_size <= SIZE_DEFAULT;
            done <= 1'b1;
          end
          idx <= idx_up;
        end
        FUNC_NEXT: begin
          if (q_fwd) begin
            if (cur_holds) begin
              area <= idx; cand <= q_addr; pend_align <= 1'b1; done <= 1'b1;
            end else if (idx != LastIdx && q_addr < up_b) begin
              area <= idx_up; cand <= up_b; pend_align <= 1'b1; done <= 1'b1;
            end else if (idx == LastIdx) begin
              res_next_address <= (tbl_size[idx] == SIZE_WORD) ? (cur_e & ~32'd3)
                                                                 : (cur_e & ~32'd1);
              done <= 1'b1;
            end
            idx <= idx_up;
          end else begin
            if (cur_holds) begin
              area <= idx; cand <= q_addr; pend_align <= 1'b1; done <= 1'b1;
            end else if (idx != '0 && q_addr > dn_e) begin
              area <= idx_dn; cand <= dn_e; pend_align <= 1'b1; done <= 1'b1;
            end else if (idx == '0) begin
              res_next_address <= tbl_begin[0];
              done <= 1'b1;
            end
            idx <= idx_dn;
          end
        end
        default: begin
          done <= 1'b1;
        end
      endcase
    end else if (cmd.align) begin
      cand <= al_addr;
    end else if (cmd.finish) begin
      pend_align <= 1'b0;
      if (tbl_begin[area] <= cand && cand <= tbl_end[area]) begin
        res_next_address <= cand;
      end else if (q_fwd) begin
        res_next_address <= (area != LastIdx) ? tbl_begin[area_up] : q_base;
      end else begin
        res_next_address <= (area != '0) ? tbl_end[area_dn] : q_base;
      end
    end
  end

endmodule

/* src/mrac_controller.sv */
// Controller state machine for the region checker: handshake and sequencing.
// Depends on mrac_pkg.
`timescale 1ns / 1ps

module mrac_controller import mrac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  mrac_stat_t stat,
  output mrac_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ALIGN, S_FINISH, S_OUT
  } state_t;

  state_t state;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.step    = (state == S_SCAN) && !stat.scan_done;
    cmd.align   = (state == S_ALIGN);
    cmd.finish  = (state == S_FINISH);
  end

  // State register and registered output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= stat.is_load ? S_OUT : S_SCAN;
            out_valid <= stat.is_load;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            if (stat.need_align) begin
              state <= S_ALIGN;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        S_ALIGN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* src/memory_region_access_checker_unit.sv */
// Top level of the memory region access checker.
// Depends on mrac_pkg, mrac_controller and mrac_datapath.
`timescale 1ns / 1ps

// One word in, one word out. A load skips the scan; a check, size or find-next query
// scans the region table one entry per cycle, and a find-next query that finds a region
// then passes through the align and finish states. The scan through the table entries
// sets the rate, and a new word is taken only after the previous result has been delivered.
module memory_region_access_checker_unit import mrac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [3:0]  entry_index,
  input  logic [31:0] entry_begin,
  input  logic [31:0] entry_end,
  input  logic        entry_read_ok,
  input  logic        entry_write_ok,
  input  logic [7:0]  entry_id,
  input  logic [2:0]  entry_access_size,
  input  logic [31:0] address,
  input  logic [15:0] word_count,
  input  logic [31:0] base_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic [7:0]  matched_id,
  output logic [2:0]  access_size,
  output logic [31:0] next_address
);

  mrac_cmd_t  cmd;
  mrac_stat_t stat;

  mrac_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  mrac_datapath u_dp (
    .clk, .rst, .cmd, .stat, .func, .entry_index, .entry_begin, .entry_end,
    .entry_read_ok, .entry_write_ok, .entry_id, .entry_access_size, .address,
    .word_count, .base_address,
    .res_granted(granted), .res_matched_id(matched_id),
    .res_access_size(access_size), .res_next_address(next_address)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for memory_region_access_checker_unit.
// Depends on mrac_pkg; loads the region table, then checks queries against an internal predictor.
`timescale 1ns / 1ps

module tb_top;
  import mrac_pkg::*;

  localparam int NumItems   = 1850;
  localparam int MaxIdle    = 16;
  localparam int StuckLimit = 4000;
  localparam int TailCycles = 40;

  // One input word as it is presented to the block.
  typedef struct {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        rd_ok;
    logic        wr_ok;
    logic [7:0]  ident;
    logic [2:0]  size;
    logic [31:0] addr;
    logic [15:0] words;
    logic [31:0] base;
    bit          drain;  // hold this word back until all answers are in
  } req_t;

  // One answer word.
  typedef struct {
    logic        granted;
    logic [7:0]  id;
    logic [2:0]  size;
    logic [31:0] next;
  } ans_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [3:0]  entry_index = '0;
  logic [31:0] entry_begin = '0;
  logic [31:0] entry_end = '0;
  logic        entry_read_ok = 1'b0;
  logic        entry_write_ok = 1'b0;
  logic [7:0]  entry_id = '0;
  logic [2:0]  entry_access_size = '0;
  logic [31:0] address = '0;
  logic [15:0] word_count = '0;
  logic [31:0] base_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        granted;
  logic [7:0]  matched_id;
  logic [2:0]  access_size;
  logic [31:0] next_address;

  memory_region_access_checker_unit i_dut (
    .clk, .rst, .in_valid, .in_stall, .func, .entry_index, .entry_begin, .entry_end,
    .entry_read_ok, .entry_write_ok, .entry_id, .entry_access_size, .address,
    .word_count, .base_address, .out_valid, .out_stall, .granted, .matched_id,
    .access_size, .next_address
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_words[$];
  ans_t awaited_answers[$];
  int   mismatches = 0;

  // Predicted region table.
  logic [31:0] tbl_lo[Regions];
  logic [31:0] tbl_hi[Regions];
  logic        tbl_rd[Regions];
  logic        tbl_wr[Regions];
  logic [7:0]  tbl_id[Regions];
  logic [2:0]  tbl_size[Regions];

  // Table shape seen by the stimulus generator, used to aim addresses.
  logic [31:0] plan_lo[Regions];
  logic [31:0] plan_hi[Regions];

  function automatic bit in_region(int r, logic [31:0] a);
    return tbl_lo[r] <= a && a <= tbl_hi[r];
  endfunction

  function automatic ans_t check_span(logic [31:0] a, logic [15:0] w, bit is_wr);
    ans_t res = '{default: '0};
    logic [31:0] last = a + ({16'd0, w} << 1) - 32'd1;
    bit done = 0;
    if (last > a) begin
      for (int r = 0; r < Regions; r++) begin
        if (!done && tbl_lo[r] <= a && last <= tbl_hi[r]) begin
          done = 1;
          if (is_wr ? tbl_wr[r] : tbl_rd[r]) begin
            res.granted = 1'b1;
            res.id = tbl_id[r];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] size_at(logic [31:0] a);
    for (int r = 0; r < Regions; r++)
      if (in_region(r, a)) return tbl_size[r];
    return SIZE_DEFAULT;
  endfunction

  function automatic logic [31:0] next_stop(logic [31:0] a, logic [31:0] base);
    bit fwd = a >= base;
    int area = -1;
    if (fwd) begin
      for (int r = 0; r < Regions; r++) begin
        if (area < 0 && in_region(r, a)) area = r;
        else if (area < 0 && r != Regions - 1 && a < tbl_lo[r + 1]) begin
          a = tbl_lo[r + 1];
          area = r + 1;
        end
      end
      if (area < 0)
        return (tbl_size[Regions - 1] == SIZE_WORD) ? tbl_hi[Regions - 1] & ~32'd3
                                                    : tbl_hi[Regions - 1] & ~32'd1;
    end else begin
      for (int r = Regions - 1; r >= 0; r--) begin
        if (area < 0 && in_region(r, a)) area = r;
        else if (area < 0 && r != 0 && a > tbl_hi[r - 1]) begin
          a = tbl_hi[r - 1];
          area = r - 1;
        end
      end
      if (area < 0) return tbl_lo[0];
    end
    // Align toward the search direction.
    if (tbl_size[area] == SIZE_WORD) a = fwd ? ((a + 32'd3) & ~32'd3) : (a & ~32'd3);
    else if (tbl_size[area] == SIZE_HALF) a = fwd ? ((a + 32'd1) & ~32'd1) : (a & ~32'd1);
    if (in_region(area, a)) return a;
    if (fwd) return (area + 1 < Regions) ? tbl_lo[area + 1] : base;
    return (area > 0) ? tbl_hi[area - 1] : base;
  endfunction

  // Apply one accepted word to the predicted table and return its answer.
  function automatic ans_t predict_answer(req_t q);
    ans_t res = '{default: '0};
    case (q.func)
      FUNC_LOAD: begin
        tbl_lo[q.slot] = q.lo;
        tbl_hi[q.slot] = q.hi;
        tbl_rd[q.slot] = q.rd_ok;
        tbl_wr[q.slot] = q.wr_ok;
        tbl_id[q.slot] = q.ident;
        tbl_size[q.slot] = q.size;
      end
      FUNC_READ:  res = check_span(q.addr, q.words, 1'b0);
      FUNC_WRITE: res = check_span(q.addr, q.words, 1'b1);
      FUNC_SIZE:  res.size = size_at(q.addr);
      FUNC_NEXT:  res.next = next_stop(q.addr, q.base);
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [2:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 3'd3;
      1, 2: return 3'd1;
      3, 4, 5: return SIZE_HALF;
      default: return SIZE_WORD;
    endcase
  endfunction

  task automatic push_load(int slot, logic [31:0] lo, logic [31:0] hi, logic [2:0] size);
    req_t q = '{default: '0};
    q.func = FUNC_LOAD;
    q.slot = slot[3:0];
    q.lo = lo;
    q.hi = hi;
    q.rd_ok = $urandom_range(0, 3) != 0;
    q.wr_ok = $urandom_range(0, 2) != 0;
    q.ident = 8'($urandom);
    q.size = size;
    q.words = 16'($urandom);
    q.addr = $urandom;
    q.base = $urandom;
    plan_lo[slot] = lo;
    plan_hi[slot] = hi;
    pending_words.push_back(q);
  endtask

  // Load a full ascending table; mode 1 spans the whole address space.
  task automatic push_table(int mode);
    logic [31:0] cur = (mode == 1) ? 32'd0 : $urandom_range(0, 4000);
    logic [31:0] len;
    if (mode == 2) cur = 32'hFFFF_F000 + $urandom_range(0, 255);
    for (int r = 0; r < Regions; r++) begin
      if (r != 0 && $urandom_range(0, 2) != 0) cur = cur + $urandom_range(1, 40);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 200);
      if (mode == 1 && r == Regions - 1) len = 32'hFFFF_FFFF - cur;
      push_load(r, cur, cur + len, pick_size());
      cur = cur + len + 1;
    end
  endtask

  function automatic logic [31:0] pick_addr();
    int r = $urandom_range(0, Regions - 1);
    int d = $urandom_range(0, 6) - 3;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      2, 3, 4: return plan_lo[r] + d;
      5, 6, 7: return plan_hi[r] + d;
      default: return plan_lo[r] + $urandom_range(0, 64);
    endcase
  endfunction

  task automatic push_query(logic [2:0] f, logic [31:0] a, logic [15:0] w, logic [31:0] b);
    req_t q = '{default: '0};
    q.func = f;
    q.addr = a;
    q.words = w;
    q.base = b;
    q.slot = 4'($urandom);
    q.lo = $urandom;
    q.hi = $urandom;
    q.ident = 8'($urandom);
    q.size = 3'($urandom);
    pending_words.push_back(q);
  endtask

  task automatic push_random_query();
    logic [2:0]  f;
    logic [31:0] a = pick_addr();
    logic [15:0] w;
    logic [31:0] b;
    case ($urandom_range(0, 39))
      0: f = FUNC_NEXT + 3'($urandom_range(1, 3));
      default: f = 3'($urandom_range(FUNC_READ, FUNC_NEXT));
    endcase
    case ($urandom_range(0, 9))
      0: w = 16'($urandom);
      1: w = 16'hFFFF;
      2: w = 16'd0;
      default: w = 16'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 5))
      0: b = $urandom;
      1, 2: b = a + $urandom_range(1, 8);
      3: b = a;
      default: b = a - $urandom_range(0, 64);
    endcase
    push_query(f, a, w, b);
  endtask

  // Stimulus: directed words first, then random sequences.
  initial begin
    push_table(0);
    push_query(FUNC_READ, plan_lo[0], 16'd1, 32'd0);
    push_query(FUNC_WRITE, plan_lo[3], 16'd2, 32'd0);
    push_query(FUNC_READ, plan_lo[2], 16'd0, 32'd0);
    push_query(FUNC_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    push_query(FUNC_READ, plan_hi[5], 16'd1, 32'd0);
    push_query(FUNC_SIZE, 32'hFFFF_FFFF, 16'd0, 32'd0);
    push_query(FUNC_SIZE, plan_lo[7], 16'd0, 32'd0);
    push_query(FUNC_NEXT, plan_lo[4] + 1, 16'd0, plan_lo[4]);
    push_query(FUNC_NEXT, plan_hi[4] - 1, 16'd0, 32'hFFFF_FFFF);
    push_query(FUNC_NEXT, 32'hFFFF_FFFF, 16'd0, 32'd0);
    push_query(FUNC_NEXT, 32'd0, 16'd0, 32'hFFFF_FFFF);
    push_query(FUNC_NEXT + 3'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    pending_words[$].drain = 1;
    while (pending_words.size() < NumItems) begin
      case ($urandom_range(0, 99))
        0, 1: push_table($urandom_range(0, 2));
        2, 3, 4, 5: begin
          int r = $urandom_range(0, Regions - 1);
          if ($urandom_range(0, 3) == 0)
            push_load(r, $urandom, $urandom, 3'($urandom_range(1, 4)));
          else push_load(r, plan_lo[r] + $urandom_range(0, 4),
                         plan_hi[r] - $urandom_range(0, 4), pick_size());
        end
        default: push_random_query();
      endcase
      if ($urandom_range(0, 199) == 0) pending_words[$].drain = 1;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: presents words with random gaps, predicting each accepted word.
  int  send_gap = 0;
  bit  send_burst = 0;
  req_t on_bus;
  always @(posedge clk) begin
    logic vld_next;
    req_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      vld_next = in_valid;
      if (in_valid && !in_stall) begin
        awaited_answers.push_back(predict_answer(on_bus));
        vld_next = 1'b0;
      end
      if (!vld_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain || awaited_answers.size() == 0)) begin
          q = pending_words.pop_front();
          on_bus = q;
          func <= q.func;
          entry_index <= q.slot;
          entry_begin <= q.lo;
          entry_end <= q.hi;
          entry_read_ok <= q.rd_ok;
          entry_write_ok <= q.wr_ok;
          entry_id <= q.ident;
          entry_access_size <= q.size;
          address <= q.addr;
          word_count <= q.words;
          base_address <= q.base;
          vld_next = 1'b1;
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MaxIdle);
        end
      end
      in_valid <= vld_next;
    end
  end

  // Monitor: random stall, compares each accepted answer with the oldest prediction.
  int  recv_gap = 0;
  bit  recv_burst = 0;
  always @(posedge clk) begin
    ans_t exp_ans;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer word with none awaited: g=%0d id=%0d sz=%0d nx=%h",
                     granted, matched_id, access_size, next_address);
        end else begin
          exp_ans = awaited_answers.pop_front();
          if (exp_ans.granted !== granted || exp_ans.id !== matched_id ||
              exp_ans.size !== access_size || exp_ans.next !== next_address) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"answer mismatch: expected g=%0d id=%0d sz=%0d nx=%h, ",
                        "got g=%0d id=%0d sz=%0d nx=%h"},
                       exp_ans.granted, exp_ans.id, exp_ans.size, exp_ans.next,
                       granted, matched_id, access_size, next_address);
          end
        end
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MaxIdle);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_stall <= recv_gap > 0;
    end
  end

  // Watchdog on cycles with no word moving on either side.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // End of run once every word is sent and every answer is in.
  // The queues and in_valid are looked at between clock edges, after all updates.
  initial begin
    @(negedge rst);
    while (pending_words.size() != 0 || in_valid || awaited_answers.size() != 0)
      @(negedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
